// File: sv/prefixed_uint_literal_parser_assert.svh
// Assertion macros used by the literal parser checker.
`ifndef PREFIXED_UINT_LITERAL_PARSER_ASSERT_SVH
`define PREFIXED_UINT_LITERAL_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PULP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PULP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulp assertion failed");

`endif

// File: sv/pulp_pkg.sv
// Types, constants and helpers for the prefixed unsigned literal parser.
package pulp_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CHAR_W          = 8;
    localparam int OUT_W           = 32;
    localparam int DIGIT_W         = 6;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ   = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_B    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_D    = 8'h64;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd36;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,   // expecting first character
        PH_PREFIX = 2'd1,   // leading zero seen, prefix letter pending
        PH_DIGITS = 2'd2    // reading digits
    } phase_t;

    typedef enum logic [1:0] {
        RDX_2  = 2'd0,
        RDX_10 = 2'd1,
        RDX_16 = 2'd2
    } radix_t;

    // Parser control state
    typedef struct packed {
        phase_t phase;
        radix_t radix;
        logic   bad;
    } ctl_t;

    // Per-beat result of the step logic
    typedef struct packed {
        logic emit;
        logic status;
    } res_t;

    localparam ctl_t CTL_RESET = '{phase: PH_FIRST, radix: RDX_10, bad: 1'b0};

    // Numeric base for a radix code
    function automatic logic [DIGIT_W-1:0] radix_val(input radix_t r);
        logic [DIGIT_W-1:0] v;
        unique case (r)
            RDX_2:   v = 6'd2;
            RDX_16:  v = 6'd16;
            default: v = 6'd10;
        endcase
        return v;
    endfunction

    // Digit value 0..35, or DIGIT_NONE for a non-digit
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        priority if (c >= CH_ZERO && c <= CH_NINE)
            d = DIGIT_W'(c - CH_ZERO);
        else if (c >= CH_UA && c <= CH_UZ)
            d = DIGIT_W'(c - CH_UA) + 6'd10;
        else if (c >= CH_LA && c <= CH_LZ)
            d = DIGIT_W'(c - CH_LA) + 6'd10;
        else
            d = DIGIT_NONE;
        return d;
    endfunction

endpackage

// File: sv/pulp_step.sv
// Combinational next-state logic for one character of the literal.
module pulp_step
    import pulp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic [CHAR_W-1:0]      char_code,
    input  ctl_t                   ctl,
    input  logic [VALUE_WIDTH-1:0] acc,
    output ctl_t                   ctl_next,
    output logic [VALUE_WIDTH-1:0] acc_next,
    output res_t                   res
);

    logic [DIGIT_W-1:0] digit;
    logic               take;

    // Constant-base multiply as shifts and adds; wraps at VALUE_WIDTH
    function automatic logic [VALUE_WIDTH-1:0] scale(input logic [VALUE_WIDTH-1:0] a,
                                                     input radix_t r);
        logic [VALUE_WIDTH-1:0] s;
        unique case (r)
            RDX_2:   s = a << 1;
            RDX_16:  s = a << 4;
            default: s = (a << 3) + (a << 1);
        endcase
        return s;
    endfunction

    assign digit = digit_of(char_code);

    always_comb
    begin
        ctl_next   = ctl;
        acc_next   = acc;
        take       = 1'b0;
        res.emit   = 1'b0;
        res.status = 1'b0;

        if (char_code == CH_NUL)
        begin
            // terminator: report and return to the idle state
            res.emit   = 1'b1;
            res.status = ctl.bad || (ctl.phase == PH_FIRST);
            ctl_next   = CTL_RESET;
            acc_next   = '0;
        end
        else
        begin
            unique case (ctl.phase)
                PH_FIRST:
                begin
                    ctl_next.radix = RDX_10;
                    acc_next       = '0;
                    if (char_code == CH_ZERO)
                    begin
                        ctl_next.phase = PH_PREFIX;
                    end
                    else
                    begin
                        ctl_next.phase = PH_DIGITS;
                        take           = 1'b1;
                    end
                end
                PH_PREFIX:
                begin
                    ctl_next.phase = PH_DIGITS;
                    priority if (char_code >= CH_ZERO && char_code <= CH_NINE)
                    begin
                        ctl_next.radix = RDX_10;
                        take           = 1'b1;
                    end
                    else if (char_code == CH_X)
                        ctl_next.radix = RDX_16;
                    else if (char_code == CH_B)
                        ctl_next.radix = RDX_2;
                    else if (char_code == CH_D)
                        ctl_next.radix = RDX_10;
                    else
                        ctl_next.bad = 1'b1;
                end
                default:
                begin
                    // digits phase; the unused code behaves the same
                    take = 1'b1;
                end
            endcase

            // fold in a digit unless an error is already latched
            if (take && !ctl.bad)
            begin
                if (digit >= radix_val(ctl_next.radix))
                    ctl_next.bad = 1'b1;
                else
                    acc_next = scale(acc_next, ctl_next.radix) + VALUE_WIDTH'(digit);
            end
        end
    end

endmodule

// File: sv/prefixed_uint_literal_parser.sv
// Streaming parser for prefixed unsigned integer literals, one character per beat.
//
//  channel  | dir | tdata            | tuser
//  ---------+-----+------------------+-------------
//  s_axis   | in  | [7:0] char_code  | -
//  m_axis   | out | [31:0] value     | [0] status
//
// One character beat per cycle unless a downstream stall holds input; the step
// is a single constant-base shift-add and range check between the input register
// and the state/result registers; a terminator's result is stored as it advances.
// Reset returns the parser to the start of a literal with no result pending.
// A downstream stall holds input only while a terminator waits for the result slot.
module prefixed_uint_literal_parser
    import pulp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] char_code
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // [31:0] value
    output logic [0:0]        m_axis_tuser    // [0] status
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [CHAR_W-1:0]      in_char_reg;
    ctl_t                   ctl_reg;
    ctl_t                   ctl_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] acc_next;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_value_reg;
    logic                   out_status_reg;
    res_t                   res;
    logic                   advance;
    logic                   s_accept;
    logic [63:0]            acc_wide;

    pulp_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .char_code (in_char_reg),
        .ctl       (ctl_reg),
        .acc       (acc_reg),
        .ctl_next  (ctl_next),
        .acc_next  (acc_next),
        .res       (res)
    );

    // Handshake: held beat moves on unless its result has nowhere to go
    assign advance       = in_valid_reg && (!res.emit || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_accept || (in_valid_reg && !advance);

    // Reported value: low 32 bits of the accumulator, zero-extended if narrower
    assign acc_wide = 64'(acc_reg);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
            in_char_reg <= s_axis_tdata;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= CTL_RESET;
            acc_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_next;
            acc_reg <= acc_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res.emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            out_status_reg <= res.status;
            out_value_reg  <= res.status ? '0 : acc_wide[OUT_W-1:0];
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_value_reg;
    assign m_axis_tuser[0] = out_status_reg;

endmodule

// File: sv/pulp_checker.sv
// Port-level checker for the literal parser, bound to the top level.
`include "prefixed_uint_literal_parser_assert.svh"

module pulp_checker
    import pulp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [CHAR_W-1:0] s_axis_tdata,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic [0:0]        m_axis_tuser
);

    // stalled result beat holds
    `PULP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // malformed literal reports a zero value
    `PULP_ASSERT_NOW(a_err_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)

    // input backpressure only comes from a stalled result
    `PULP_ASSERT_NOW(a_bp_cause, clk, rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // a held input can always drain once a stalled result is taken
    `PULP_ASSERT_NEXT(a_bp_clear, clk, rst_n, !s_axis_tready && m_axis_tready, s_axis_tready)

    // a presented character beat carries known data
    `PULP_ASSERT_NOW(a_in_known, clk, rst_n, s_axis_tvalid, !$isunknown(s_axis_tdata))

endmodule

bind prefixed_uint_literal_parser pulp_checker u_pulp_checker (.*);
